FILE: sv/wknn_pkg.sv
// wknn_pkg: shared types, constants and the weight table of the knn classifier
// no dependencies
`default_nettype none

package wknn_pkg;

  localparam int MAX_ROWS      = 1024;
  localparam int ROW_W         = 10;
  localparam int STORED_W      = 11;
  localparam int MAX_FEATURES  = 16;
  localparam int FEAT_IDX_W    = 4;
  localparam int POS_W         = 5;
  localparam int MAX_NEIGHBORS = 64;
  localparam int K_W           = 7;
  localparam int FEATURE_BITS  = 16;
  localparam int SQ_W          = 2 * FEATURE_BITS;
  localparam int SUM_W         = SQ_W + 4;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int DIST_W        = 19;
  localparam int WEIGHT_W      = 25;
  localparam int SCORE_W       = 31;
  localparam int WEIGHT_ENTRIES = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TRAIN = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEATURE_COUNT  = 1'b0,
    REG_NEIGHBOR_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FEED  = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // one neighbor slot
  typedef struct packed {
    logic [DIST_W-1:0] dst;
    logic [1:0]        lab;
  } nb_t;

  localparam nb_t NB_EMPTY = '{dst: '1, lab: 2'd0};

  // chain control
  typedef struct packed {
    logic clear;
    logic ins;
    logic shift;
  } chain_ctl_t;

  // round(2^24 * e^(-1.4*d)), zero from d = 12 on
  function automatic logic [WEIGHT_W-1:0] weight_lut(input logic [DIST_W-1:0] d);
    logic [WEIGHT_W-1:0] w;
    w = '0;
    if (d < DIST_W'(WEIGHT_ENTRIES)) begin
      case (d[3:0])
        4'd0:    w = 25'd16777216;
        4'd1:    w = 25'd4137211;
        4'd2:    w = 25'd1020224;
        4'd3:    w = 25'd251584;
        4'd4:    w = 25'd62040;
        4'd5:    w = 25'd15299;
        4'd6:    w = 25'd3773;
        4'd7:    w = 25'd930;
        4'd8:    w = 25'd229;
        4'd9:    w = 25'd57;
        4'd10:   w = 25'd14;
        4'd11:   w = 25'd3;
        default: w = '0;
      endcase
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/wknn_if.sv
// wknn_if: valid/ready channels of the knn classifier (input, result, config)
// depends on wknn_pkg
`default_nettype none

interface wknn_in_if import wknn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [FEATURE_BITS-1:0] feature_value;
  logic [1:0]              class_label;
  logic                    row_end;
  modport source (output valid, opcode, feature_value, class_label, row_end, input ready);
  modport sink   (input valid, opcode, feature_value, class_label, row_end, output ready);
endinterface

interface wknn_out_if import wknn_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] predicted_class;
  logic       table_full;
  modport source (output valid, predicted_class, table_full, input ready);
  modport sink   (input valid, predicted_class, table_full, output ready);
endinterface

interface wknn_cfg_if import wknn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/weighted_knn_classifier_unit.sv
// weighted_knn_classifier_unit: distance-weighted knn classifier, top level
// depends on wknn_pkg, wknn_if, wknn_isqrt, wknn_cell, wknn_chain
//
//  channel  dir  payload                                         word taken when
//  in_i     in   opcode, feature_value, class_label, row_end     valid & ready
//  out_o    out  predicted_class, table_full                     valid & ready
//  cfg_i    in   index (0 feature_count, 1 neighbor_count), data valid & ready
//
// ready is high while idle, and clear, training and query words are taken then
// a query word with row_end starts a scan: per stored row nf feature reads, a
// 3 stage difference/square pipe and the bit-serial square root, then k entries
// are drained from the neighbor chain
// reset clears counters, flags and the neighbor chain; feature storage is not cleared
// a result waits in the output register; a new result is held back until it is taken
`default_nettype none

module weighted_knn_classifier_unit import wknn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  wknn_in_if.sink    in_i,
  wknn_out_if.source out_o,
  wknn_cfg_if.sink   cfg_i
);

  // configuration
  logic [4:0]     fc_q;
  logic [K_W-1:0] nc_q;
  logic [POS_W-1:0] nf;
  logic [K_W-1:0]   k_eff;

  // training set bookkeeping
  logic [STORED_W-1:0] stored_q;
  logic [POS_W-1:0]    pos_q;
  logic                ovf_q;

  // controller
  state_e state_q;
  logic [ROW_W-1:0]      row_q;
  logic [FEAT_IDX_W-1:0] feat_q;
  logic [K_W-1:0]        drain_q;

  // memories
  logic [FEATURE_BITS-1:0] feat_mem [MAX_ROWS*MAX_FEATURES];
  logic [1:0]              lab_mem  [MAX_ROWS];
  logic [FEATURE_BITS-1:0] qf_mem   [MAX_FEATURES];

  // scan pipeline
  logic                    v1_q, v2_q, v3_q, l1_q, l2_q, l3_q;
  logic [FEATURE_BITS-1:0] rd_q, qf_q, absd_q;
  logic [SQ_W-1:0]         sq_q;
  logic [SUM_W-1:0]        acc_q, acc_sum;
  logic [1:0]              lab_rd_q;

  // vote
  logic [SCORE_W-1:0] score_q [3];
  logic [1:0]         winner;
  logic               out_valid_q, out_full_q;
  logic [1:0]         out_pred_q;

  logic in_fire, cfg_fire, out_take;
  logic pos_ok, room, feed_last, sqrt_start, sqrt_done, query_end, rows_done;
  logic [ROOT_W-1:0] root;
  op_e  op;
  chain_ctl_t ctl;
  nb_t  new_nb, head;

  assign op       = op_e'(in_i.opcode);
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire  = in_i.valid & in_i.ready;
  assign cfg_fire = cfg_i.valid & cfg_i.ready;
  assign out_take = out_valid_q & out_o.ready;

  // effective feature count and k, clamped to their legal ranges
  always_comb begin
    if (fc_q == '0) nf = POS_W'(1);
    else if (fc_q > POS_W'(MAX_FEATURES)) nf = POS_W'(MAX_FEATURES);
    else nf = fc_q;
    if (nc_q == '0) k_eff = K_W'(1);
    else if (nc_q > K_W'(MAX_NEIGHBORS)) k_eff = K_W'(MAX_NEIGHBORS);
    else k_eff = nc_q;
  end

  assign pos_ok    = pos_q < nf;
  assign room      = stored_q < STORED_W'(MAX_ROWS);
  assign query_end = in_fire & (op == OP_QUERY) & in_i.row_end;
  assign feed_last = ({1'b0, feat_q} == nf - 1'b1);
  assign rows_done = ({1'b0, row_q} + 1'b1) == stored_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= 5'd8;
      nc_q <= K_W'(5);
    end else if (cfg_fire) begin
      case (cfg_i.index)
        REG_FEATURE_COUNT:  fc_q <= cfg_i.data[4:0];
        REG_NEIGHBOR_COUNT: nc_q <= cfg_i.data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // input words: row assembly, clear and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      pos_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (in_fire) begin
      case (op)
        OP_CLEAR: begin
          stored_q <= '0;
          pos_q    <= '0;
          ovf_q    <= 1'b0;
        end
        OP_TRAIN, OP_QUERY: begin
          if (!in_i.row_end) begin
            if (pos_q < POS_W'(MAX_FEATURES)) pos_q <= pos_q + 1'b1;
          end else begin
            pos_q <= '0;
            if (op == OP_TRAIN) begin
              if (room) stored_q <= stored_q + 1'b1;
              else ovf_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // training storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (in_fire && op == OP_TRAIN && pos_ok && room) begin
      feat_mem[{stored_q[ROW_W-1:0], pos_q[FEAT_IDX_W-1:0]}] <= in_i.feature_value;
    end
    rd_q <= feat_mem[{row_q, feat_q}];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && op == OP_TRAIN && in_i.row_end && room) begin
      lab_mem[stored_q[ROW_W-1:0]] <= in_i.class_label;
    end
    lab_rd_q <= lab_mem[row_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && op == OP_QUERY && pos_ok) begin
      qf_mem[pos_q[FEAT_IDX_W-1:0]] <= in_i.feature_value;
    end
    qf_q <= qf_mem[feat_q];
  end

  // controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      feat_q  <= '0;
      drain_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (query_end) begin
            row_q   <= '0;
            feat_q  <= '0;
            drain_q <= k_eff;
            state_q <= (stored_q == '0) ? ST_DRAIN : ST_FEED;
          end
        end
        ST_FEED: begin
          feat_q <= feat_q + 1'b1;
          if (feed_last) state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          // root ready: chain takes it this cycle, move on to next row or drain after the last
          if (sqrt_done) begin
            feat_q <= '0;
            if (rows_done) begin
              state_q <= ST_DRAIN;
            end else begin
              row_q   <= row_q + 1'b1;
              state_q <= ST_FEED;
            end
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q - 1'b1;
          if (drain_q == K_W'(1)) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // difference / square / accumulate pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      l1_q <= 1'b0; l2_q <= 1'b0; l3_q <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_FEED);
      l1_q <= (state_q == ST_FEED) & feed_last;
      v2_q <= v1_q; l2_q <= l1_q;
      v3_q <= v2_q; l3_q <= l2_q;
    end
  end

  assign acc_sum    = acc_q + SUM_W'(sq_q);
  assign sqrt_start = v3_q & l3_q;

  always_ff @(posedge clk_i) begin
    absd_q <= (qf_q >= rd_q) ? qf_q - rd_q : rd_q - qf_q;
    sq_q   <= absd_q * absd_q;
    if (query_end || sqrt_start) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_sum;
    end
  end

  wknn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (acc_sum),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // neighbor chain: cleared per query, one insert per row, drained for the vote
  assign new_nb.dst = DIST_W'(root);
  assign new_nb.lab = (lab_rd_q == 2'd1 || lab_rd_q == 2'd2) ? lab_rd_q : 2'd0;
  assign ctl.clear  = query_end;
  assign ctl.ins    = (state_q == ST_WAIT) & sqrt_done;
  assign ctl.shift  = (state_q == ST_DRAIN);

  wknn_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .new_i  (new_nb),
    .head_o (head)
  );

  // class scores, one neighbor per drain cycle
  always_ff @(posedge clk_i) begin
    if (query_end) begin
      score_q[0] <= '0;
      score_q[1] <= '0;
      score_q[2] <= '0;
    end else if (state_q == ST_DRAIN) begin
      score_q[head.lab] <= score_q[head.lab] + SCORE_W'(weight_lut(head.dst));
    end
  end

  // strict wins only, every tie goes to class 2
  always_comb begin
    if (score_q[0] > score_q[1] && score_q[0] > score_q[2]) winner = 2'd0;
    else if (score_q[1] > score_q[0] && score_q[1] > score_q[2]) winner = 2'd1;
    else winner = 2'd2;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
      out_pred_q <= winner;
      out_full_q <= ovf_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.predicted_class = out_pred_q;
  assign out_o.table_full      = out_full_q;

endmodule

`default_nettype wire

FILE: sv/wknn_cell.sv
// wknn_cell: one slot of the sorted neighbor chain
// depends on wknn_pkg
`default_nettype none

module wknn_cell import wknn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  input  nb_t        new_i,
  input  nb_t        prev_i,
  input  nb_t        next_i,
  output nb_t        ent_o
);

  nb_t ent_d, ent_q;
  logic take_new, prev_le;

  assign take_new = new_i.dst < ent_q.dst;
  assign prev_le  = prev_i.dst <= new_i.dst;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.clear) begin
      ent_d = NB_EMPTY;
    end else if (ctl_i.ins) begin
      // new entry lands after equal distances, larger ones move down
      if (take_new) begin
        ent_d = prev_le ? new_i : prev_i;
      end
    end else if (ctl_i.shift) begin
      ent_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= NB_EMPTY;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

FILE: sv/wknn_chain.sv
// wknn_chain: row of neighbor cells, sorted by distance, drained at the head
// depends on wknn_pkg, wknn_cell
`default_nettype none

module wknn_chain import wknn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  input  nb_t        new_i,
  output nb_t        head_o
);

  nb_t ent [MAX_NEIGHBORS];

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    nb_t prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = ent[i-1];
    end
    if (i == MAX_NEIGHBORS - 1) begin : g_last
      assign next_w = NB_EMPTY;
    end else begin : g_inner
      assign next_w = ent[i+1];
    end
    wknn_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_i),
      .new_i  (new_i),
      .prev_i (prev_w),
      .next_i (next_w),
      .ent_o  (ent[i])
    );
  end

  assign head_o = ent[0];

endmodule

`default_nettype wire

FILE: sv/wknn_isqrt.sv
// wknn_isqrt: floor square root, one result bit per cycle
// depends on wknn_pkg
`default_nettype none

module wknn_isqrt import wknn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  value_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  val_q;
  logic [REM_W-1:0]  rem_q, rem_sh;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  trial;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q, done_q;

  assign rem_sh = {rem_q[REM_W-3:0], val_q[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(ROOT_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      val_q <= {val_q[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: sv/wknn_checker.sv
// wknn_checker: port level checks of the knn classifier, bound to the top level
// depends on wknn_pkg, weighted_knn_classifier_unit
`default_nettype none

module wknn_checker import wknn_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       in_row_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_pred,
  input logic       out_full
);

  // a waiting result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pred) && $stable(out_full))
    else $error("result word changed while stalled");

  // only three classes exist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_pred != 2'd3)
    else $error("predicted class out of range");

  // a query end starts a scan, no word is taken in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_opcode == OP_QUERY && in_row_end |=> !in_ready)
    else $error("input taken during scan");

  // clear words never produce a result by themselves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_opcode == OP_CLEAR && !out_valid |=> !out_valid)
    else $error("result after clear word");

endmodule

bind weighted_knn_classifier_unit wknn_checker u_wknn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .in_opcode  (in_i.opcode),
  .in_row_end (in_i.row_end),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_pred   (out_o.predicted_class),
  .out_full   (out_o.table_full)
);

`default_nettype wire
